@@ hdl/sha1h_pkg.sv @@
// Shared types, constants and helper functions for the SHA-1 message hasher.
// Depends on nothing; the round unit, the sequencer, the top level and the testbench import it.
package sha1h_pkg;

	localparam int unsigned NUM_H = 5;
	localparam int unsigned NUM_W = 16;
	localparam int unsigned IDX_W = $clog2(NUM_H);

	typedef logic [31:0] word_t;
	typedef logic [6:0]  round_t;
	typedef logic [5:0]  pos_t;
	typedef logic [63:0] count_t;
	typedef logic [IDX_W-1:0] idx_t;

	localparam word_t H_INIT [NUM_H] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam word_t K_R0 = 32'h5A827999;
	localparam word_t K_R1 = 32'h6ED9EBA1;
	localparam word_t K_R2 = 32'h8F1BBCDC;
	localparam word_t K_R3 = 32'hCA62C1D6;

	localparam round_t ROUND_20   = 7'd20;
	localparam round_t ROUND_40   = 7'd40;
	localparam round_t ROUND_60   = 7'd60;
	localparam round_t ROUND_LAST = 7'd79;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam pos_t       LEN_POS  = 6'd56;
	localparam pos_t       LAST_POS = 6'd63;
	localparam logic [2:0] LEN_LAST = 3'd7;
	localparam idx_t       IDX_LAST = idx_t'(NUM_H - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_ADD,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		PUT_DATA,
		PUT_MARK,
		PUT_ZERO,
		PUT_LEN
	} put_sel_t;

	typedef struct packed {
		logic     in_ready;
		logic     put_en;
		put_sel_t put_sel;
		logic     push_word;
		logic     load_vars;
		logic     round_en;
		round_t   round_idx;
		logic     add_en;
		logic     fin_load;
		logic     pad_start;
		logic     len_shift;
	} ctrl_t;

	function automatic word_t rotl(word_t x, int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

endpackage

@@ hdl/sha1h_if.sv @@
// Channel interfaces of the SHA-1 hasher: message bytes in, digest words out.
// Valid/ready handshake; no dependencies.
interface sha1h_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] msg_byte;
	logic       byte_present;
	logic       message_end;

	modport source (output valid, msg_byte, byte_present, message_end, input ready);
	modport sink   (input valid, msg_byte, byte_present, message_end, output ready);
endinterface

interface sha1h_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ hdl/sha1h_round.sv @@
// One SHA-1 round and one message schedule step, shared by all 80 rounds.
// Depends on sha1h_pkg.
module sha1h_round (
	input  sha1h_pkg::word_t  a,
	input  sha1h_pkg::word_t  b,
	input  sha1h_pkg::word_t  c,
	input  sha1h_pkg::word_t  d,
	input  sha1h_pkg::word_t  e,
	input  sha1h_pkg::word_t  w0,
	input  sha1h_pkg::word_t  w2,
	input  sha1h_pkg::word_t  w8,
	input  sha1h_pkg::word_t  w13,
	input  sha1h_pkg::round_t t,
	output sha1h_pkg::word_t  a_next,
	output sha1h_pkg::word_t  c_next,
	output sha1h_pkg::word_t  w_next
);
	import sha1h_pkg::*;

	word_t f;
	word_t k;

	always_comb begin
		if (t < ROUND_20) begin
			f = (b & c) | (~b & d);
			k = K_R0;
		end else if (t < ROUND_40) begin
			f = b ^ c ^ d;
			k = K_R1;
		end else if (t < ROUND_60) begin
			f = (b & c) | (b & d) | (c & d);
			k = K_R2;
		end else begin
			f = b ^ c ^ d;
			k = K_R3;
		end
	end

	// During the rounds the schedule window holds W[t..t+15], so W[t] is its oldest word.
	assign a_next = rotl(a, 5) + f + e + k + w0;
	assign c_next = rotl(b, 30);
	assign w_next = rotl(w13 ^ w8 ^ w2 ^ w0, 1);

endmodule

@@ hdl/sha1h_ctrl.sv @@
// Sequencer of the SHA-1 hasher: byte position, padding phases and round count.
// Depends on sha1h_pkg; drives the datapath through a ctrl_t struct.
module sha1h_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_present,
	input  logic             in_end,
	input  logic             out_busy,
	output sha1h_pkg::ctrl_t ctrl
);
	import sha1h_pkg::*;

	state_t     state_q;
	state_t     state_d;
	state_t     ret_q;
	state_t     ret_d;
	round_t     round_q;
	pos_t       pos_q;
	logic       pad_mark_q;
	logic       pad_len_q;
	logic [2:0] len_idx_q;
	logic       in_hs;

	assign in_hs = in_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_hs) begin
					if (in_present && pos_q == LAST_POS) begin
						state_d = ST_COMP;
						ret_d   = in_end ? ST_PAD : ST_IDLE;
					end else if (in_end) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (pos_q == LAST_POS) begin
					state_d = ST_COMP;
					ret_d   = (pad_len_q && len_idx_q == LEN_LAST) ? ST_FIN : ST_PAD;
				end
			end
			ST_COMP: begin
				if (round_q == ROUND_LAST) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				state_d = ret_q;
			end
			ST_FIN: begin
				if (!out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.in_ready  = 1'b1;
				ctrl.put_en    = in_hs && in_present;
				ctrl.put_sel   = PUT_DATA;
				ctrl.pad_start = in_hs && in_end;
			end
			ST_PAD: begin
				ctrl.put_en    = 1'b1;
				ctrl.put_sel   = pad_mark_q ? PUT_MARK : (pad_len_q ? PUT_LEN : PUT_ZERO);
				ctrl.len_shift = pad_len_q && !pad_mark_q;
			end
			ST_COMP: begin
				ctrl.round_en = 1'b1;
			end
			ST_ADD: begin
				ctrl.add_en = 1'b1;
			end
			ST_FIN: begin
				ctrl.fin_load = !out_busy;
			end
			default: begin
				ctrl.in_ready = 1'b0;
			end
		endcase
		ctrl.push_word = ctrl.put_en && (pos_q[1:0] == 2'd3);
		ctrl.load_vars = ctrl.put_en && (pos_q == LAST_POS);
		ctrl.round_idx = round_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ret_q      <= ST_IDLE;
			round_q    <= '0;
			pos_q      <= '0;
			pad_mark_q <= 1'b0;
			pad_len_q  <= 1'b0;
			len_idx_q  <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (ctrl.round_en) begin
				round_q <= (round_q == ROUND_LAST) ? '0 : round_q + 7'd1;
			end
			if (ctrl.put_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (ctrl.pad_start) begin
				pad_mark_q <= 1'b1;
				pad_len_q  <= 1'b0;
				len_idx_q  <= '0;
			end else if (state_q == ST_PAD) begin
				pad_mark_q <= 1'b0;
				if (pad_len_q) begin
					len_idx_q <= len_idx_q + 3'd1;
				end else if (pos_q + 6'd1 == LEN_POS) begin
					pad_len_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ hdl/sha1_message_hasher.sv @@
// Top level of the SHA-1 message hasher: chaining words, block buffer and digest output.
// Depends on sha1h_pkg, sha1h_if, sha1h_round and sha1h_ctrl.
//
// Use: message bytes arrive on the msg channel, one beat per byte, in message order.
// A beat with byte_present low carries no byte; with message_end high it closes the
// message (a byte on the same beat is taken first), so an empty message can be hashed.
// The digest leaves on the digest channel as five beats, H0 first, word_index 0 to 4,
// last_word high on the fifth. After the end beat the block pads and compresses, then
// returns to the initial chaining value for the next message.
// Throughput: ordinary bytes are taken at one per cycle while the block is idle. The
// 64th byte of a block starts a compression, one round per cycle through the single
// round unit, then a step that folds the result into the chaining words; no byte is
// taken meanwhile. Padding inserts one pad byte per cycle, so an end beat costs the
// pad bytes plus one or two compressions and a step that moves the digest into the
// output buffer. The digest sits in its own buffer, so the next message is taken
// while the receiver stalls; the following digest waits until the buffer has drained,
// and no message beats are taken while it waits.
// Reset clears the sequencer, the bit count and the output buffer's busy flag and index
// and loads the initial chaining value; the block is ready as soon as reset is released.
module sha1_message_hasher (
	input  logic       clk,
	input  logic       arst_n,
	sha1h_msg_if.sink  msg,
	sha1h_dig_if.source digest
);
	import sha1h_pkg::*;

	ctrl_t      ctrl;
	logic       out_busy_q;
	idx_t       out_idx_q;
	word_t      word_q;
	word_t      line_q  [NUM_W];
	word_t      var_q   [NUM_H];
	word_t      chain_q [NUM_H];
	word_t      dig_q   [NUM_H];
	count_t     bits_q;
	count_t     bits_d;
	count_t     len_q;
	logic [7:0] put_val;
	word_t      push_val;
	word_t      a_next;
	word_t      c_next;
	word_t      w_next;
	logic       out_hs;

	sha1h_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (msg.valid),
		.in_present (msg.byte_present),
		.in_end     (msg.message_end),
		.out_busy   (out_busy_q),
		.ctrl       (ctrl)
	);

	sha1h_round u_round (
		.a      (var_q[0]),
		.b      (var_q[1]),
		.c      (var_q[2]),
		.d      (var_q[3]),
		.e      (var_q[4]),
		.w0     (line_q[0]),
		.w2     (line_q[2]),
		.w8     (line_q[8]),
		.w13    (line_q[13]),
		.t      (ctrl.round_idx),
		.a_next (a_next),
		.c_next (c_next),
		.w_next (w_next)
	);

	assign msg.ready = ctrl.in_ready;

	// Bit count including the byte of the current beat; this is the length
	// that goes into the padding when the beat also ends the message.
	assign bits_d = bits_q + (msg.byte_present ? 64'd8 : 64'd0);

	always_comb begin
		case (ctrl.put_sel)
			PUT_DATA: put_val = msg.msg_byte;
			PUT_MARK: put_val = PAD_BYTE;
			PUT_LEN:  put_val = len_q[63:56];
			default:  put_val = 8'h00;
		endcase
	end

	// Bytes collect big-endian in word_q; the fourth byte completes a word.
	assign push_val = {word_q[23:0], put_val};

	always_ff @(posedge clk) begin
		if (ctrl.put_en) begin
			word_q <= push_val;
		end
		// The buffer doubles as the schedule window: loading shifts words in,
		// and each round shifts in the next schedule word.
		if (ctrl.push_word || ctrl.round_en) begin
			for (int i = 0; i < NUM_W - 1; i++) begin
				line_q[i] <= line_q[i + 1];
			end
			line_q[NUM_W - 1] <= ctrl.push_word ? push_val : w_next;
		end
		if (ctrl.load_vars) begin
			for (int i = 0; i < NUM_H; i++) begin
				var_q[i] <= chain_q[i];
			end
		end else if (ctrl.round_en) begin
			var_q[0] <= a_next;
			var_q[1] <= var_q[0];
			var_q[2] <= c_next;
			var_q[3] <= var_q[2];
			var_q[4] <= var_q[3];
		end
		if (ctrl.pad_start) begin
			len_q <= bits_d;
		end else if (ctrl.len_shift) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (ctrl.fin_load) begin
			for (int i = 0; i < NUM_H; i++) begin
				dig_q[i] <= chain_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_H; i++) begin
				chain_q[i] <= H_INIT[i];
			end
			bits_q <= '0;
		end else begin
			if (ctrl.add_en) begin
				for (int i = 0; i < NUM_H; i++) begin
					chain_q[i] <= chain_q[i] + var_q[i];
				end
			end else if (ctrl.fin_load) begin
				for (int i = 0; i < NUM_H; i++) begin
					chain_q[i] <= H_INIT[i];
				end
			end
			if (ctrl.in_ready && msg.valid) begin
				bits_q <= msg.message_end ? '0 : bits_d;
			end
		end
	end

	assign out_hs = digest.valid && digest.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_busy_q <= 1'b0;
			out_idx_q  <= '0;
		end else if (ctrl.fin_load) begin
			out_busy_q <= 1'b1;
			out_idx_q  <= '0;
		end else if (out_hs) begin
			if (out_idx_q == IDX_LAST) begin
				out_busy_q <= 1'b0;
			end else begin
				out_idx_q <= out_idx_q + idx_t'(1);
			end
		end
	end

	assign digest.valid       = out_busy_q;
	assign digest.digest_word = dig_q[out_idx_q];
	assign digest.word_index  = out_idx_q;
	assign digest.last_word   = (out_idx_q == IDX_LAST);

endmodule

@@ hdl/sha1h_checker.sv @@
// Port-level checks on the digest channel of the SHA-1 hasher, bound to the top level.
// Depends on sha1_message_hasher and its interface ports.
module sha1h_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_word,
	input logic [2:0]  out_index,
	input logic        out_last
);

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (out_index == 3'd4)))
		else $error("last_word does not match word_index four");

	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (out_index == 3'd0))
		else $error("digest does not start with word zero");

	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_last) |=>
			(out_valid && out_index == $past(out_index) + 3'd1))
		else $error("digest words not delivered in order");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_word) && $stable(out_index)))
		else $error("stalled digest beat changed");

endmodule

bind sha1_message_hasher sha1h_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (digest.valid),
	.out_ready (digest.ready),
	.out_word  (digest.digest_word),
	.out_index (digest.word_index),
	.out_last  (digest.last_word)
);

@@ test/sha1_message_hasher_test.sv @@
// Self-checking testbench of sha1_message_hasher: directed table, then random messages.
// Depends on sha1h_pkg, sha1h_if and the block itself; predicts each digest not typed in.
`timescale 1ns / 100ps

module sha1_message_hasher_test;
	import sha1h_pkg::*;

	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 8;
	// Random beats that carry a byte or close a message; idle beats are not counted.
	// With the directed table and the idle beats this comes to about 170 beats in all.
	localparam int RANDOM_BEATS = 140;
	localparam int MIN_RANDOM_MESSAGES = 12;
	// The first few random messages are short, so that they pile up during the hold-off.
	localparam int PILE_MESSAGES = 6;
	// Long receiver hold-off, long enough for the digest buffer to fill and the block to refuse message beats.
	localparam int HOLD_CYCLES = 1500;
	// After the last digest word: the padding, two compressions and the output move.
	localparam int DRAIN_CYCLES = 400;
	localparam int CYCLE_LIMIT  = 200000;

	// Message lengths either side of the single/double final block boundary.
	localparam int BOUNDARY_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 128};

	// Initial chaining value and round constants of the predictor.
	localparam word_t IV [NUM_H] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};
	localparam word_t RK [4] = '{32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6};
	localparam logic [7:0] MARK_BYTE = 8'h80;
	localparam pos_t LENGTH_OFFSET   = 6'd56;
	localparam pos_t FINAL_OFFSET    = 6'd63;

	localparam logic [159:0] DIGEST_EMPTY =
		160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
	localparam logic [159:0] DIGEST_ABC =
		160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

	// One row of the directed table. Where known is set the digest is typed in;
	// otherwise the predictor supplies it.
	typedef struct packed {
		logic [7:0]   data;
		logic         present;
		logic         closes;
		logic         known;
		logic [159:0] digest;
	} stim_row_t;

	localparam int TABLE_ROWS = 14;
	localparam stim_row_t STIMULUS_TABLE [TABLE_ROWS] = '{
		// Empty message straight after reset.
		'{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
		// A beat with neither byte nor end must change nothing.
		'{8'hFF, 1'b0, 1'b0, 1'b0, '0},
		// "abc", closed on the same beat as its last byte.
		'{8'h61, 1'b1, 1'b0, 1'b0, '0},
		'{8'h62, 1'b1, 1'b0, 1'b0, '0},
		'{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},
		// A single zero byte.
		'{8'h00, 1'b1, 1'b1, 1'b0, '0},
		// Extreme bytes with an idle beat in the middle, closed by an end-only beat
		// whose byte field must be ignored.
		'{8'hFF, 1'b1, 1'b0, 1'b0, '0},
		'{8'h5A, 1'b0, 1'b0, 1'b0, '0},
		'{8'h80, 1'b1, 1'b0, 1'b0, '0},
		'{8'h01, 1'b1, 1'b0, 1'b0, '0},
		'{8'hC3, 1'b0, 1'b1, 1'b0, '0},
		// A single all-ones byte.
		'{8'hFF, 1'b1, 1'b1, 1'b0, '0},
		// Two empty messages back to back, after the chain has been used.
		'{8'hFF, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
		'{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY}
	};

	typedef struct {
		word_t      dword;
		logic [2:0] windex;
		logic       wlast;
	} digest_beat_t;

	typedef enum int {
		RX_OPEN,
		RX_CHOPPY,
		RX_SLUGGISH
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	sha1h_msg_if msg ();
	sha1h_dig_if digest ();

	sha1_message_hasher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.digest (digest)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Predictor state: chaining words, bit count and the 16-word block being filled.
	word_t  chain_h [NUM_H];
	count_t bit_count;
	word_t  block_buf [NUM_H == 5 ? NUM_W : NUM_W];

	// Digest words still owed by the block, oldest first.
	digest_beat_t pending_digest_words [$];

	int  mismatches     = 0;
	int  beats_sent     = 0;
	int  idle_beats     = 0;
	int  words_checked  = 0;
	int  cycles         = 0;
	int  burst_left     = 0;
	bit  hold_req       = 1'b0;
	int  held_cycles    = 0;

	// Eighty rounds over the current block, folded into the chaining words.
	function automatic void compress_block();
		word_t sched [NUM_W];
		word_t a, b, c, d, e, f, k, x, tmp;
		sched = block_buf;
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int t = 0; t < 80; t++) begin
			if (t < 16) begin
				x = sched[t];
			end else begin
				x = sched[(t + 13) % 16] ^ sched[(t + 8) % 16] ^ sched[(t + 2) % 16] ^
					sched[t % 16];
				x = {x[30:0], x[31]};
				sched[t % 16] = x;
			end
			if (t < 20) begin
				f = (b & c) | (~b & d);
				k = RK[0];
			end else if (t < 40) begin
				f = b ^ c ^ d;
				k = RK[1];
			end else if (t < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = RK[2];
			end else begin
				f = b ^ c ^ d;
				k = RK[3];
			end
			tmp = {a[26:0], a[31:27]} + f + e + k + x;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = tmp;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endfunction

	// Bytes go in big-endian within each word; a word is cleared by its first byte.
	function automatic void place_byte(input pos_t pos, input logic [7:0] data);
		if (pos[1:0] == 2'd0)
			block_buf[pos[5:2]] = '0;
		block_buf[pos[5:2]][8 * (3 - pos[1:0]) +: 8] = data;
		if (pos == FINAL_OFFSET)
			compress_block();
	endfunction

	// Advance the predictor by one accepted beat. Returns 1 and the digest when the
	// beat closes the message, after which the chain starts afresh.
	function automatic bit hash_beat(input logic [7:0] data, input logic present,
			input logic closes, output word_t dig [NUM_H]);
		pos_t   pos;
		count_t len;
		dig = chain_h;
		if (present) begin
			pos = bit_count[8:3];
			bit_count += 64'd8;
			place_byte(pos, data);
		end
		if (!closes)
			return 1'b0;
		len = bit_count;
		pos = len[8:3];
		place_byte(pos, MARK_BYTE);
		pos++;
		while (pos != LENGTH_OFFSET) begin
			place_byte(pos, 8'h00);
			pos++;
		end
		for (int i = 0; i < 8; i++) begin
			place_byte(pos, len[63 - 8 * i -: 8]);
			pos++;
		end
		dig = chain_h;
		chain_h = IV;
		bit_count = '0;
		return 1'b1;
	endfunction

	// Offer one beat and hold it until it is taken. The sender works in bursts:
	// when a burst runs out, valid drops for a random gap before the beat goes out.
	// Called at a rising edge; returns at the edge that took the beat.
	task automatic send_beat(input logic [7:0] data, input logic present, input logic closes,
			input logic known, input logic [159:0] typed);
		word_t dig [NUM_H];
		int    gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			msg.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		msg.valid        <= 1'b1;
		msg.msg_byte     <= data;
		msg.byte_present <= present;
		msg.message_end  <= closes;
		@(posedge clk);
		while (!msg.ready)
			@(posedge clk);
		burst_left--;
		if (present || closes)
			beats_sent++;
		else
			idle_beats++;
		if (hash_beat(data, present, closes, dig)) begin
			for (int i = 0; i < NUM_H; i++)
				pending_digest_words.push_back('{
					dword:  known ? typed[159 - 32 * i -: 32] : dig[i],
					windex: 3'(i),
					wlast:  (i == NUM_H - 1)
				});
		end
	endtask

	// A random message of the given length, with idle beats sprinkled in. It is closed
	// either on its last byte or by a separate end-only beat with a junk byte.
	task automatic send_message(input int len);
		logic close_on_byte;
		close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0)
				send_beat(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
			send_beat(8'($urandom), 1'b1, close_on_byte && (i == len - 1), 1'b0, '0);
		end
		if (!close_on_byte)
			send_beat(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
	endtask

	// Receiver. It changes mood at random times between always ready, choppy and
	// mostly stalled. Once asked, it holds ready low for a long stretch, so that the
	// digest buffer fills and the block has to refuse further message beats.
	initial begin : digest_receiver
		rx_mode_t mode;
		int       seg_left;
		int       hold_left;
		bit       hold_taken;
		mode       = RX_OPEN;
		seg_left   = 0;
		hold_left  = 0;
		hold_taken = 1'b0;
		digest.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				held_cycles++;
				digest.ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode     = rx_mode_t'($urandom_range(0, 2));
					seg_left = $urandom_range(8, 64);
				end else begin
					seg_left--;
				end
				case (mode)
					RX_OPEN: begin
						digest.ready <= 1'b1;
					end
					RX_CHOPPY: begin
						digest.ready <= ($urandom_range(0, 1) == 1);
					end
					default: begin
						digest.ready <= ($urandom_range(0, 3) == 0);
					end
				endcase
			end
		end
	end

	// Every digest beat taken is checked against the oldest word still owed.
	always @(posedge clk) begin : digest_check
		digest_beat_t want;
		if (arst_n && digest.valid && digest.ready) begin
			if (pending_digest_words.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected digest beat: expected none, got %h index %0d last %b",
					$time, digest.digest_word, digest.word_index, digest.last_word);
			end else begin
				want = pending_digest_words.pop_front();
				words_checked++;
				if (digest.digest_word !== want.dword) begin
					mismatches++;
					$display("%0t: digest_word expected %h, got %h", $time, want.dword,
						digest.digest_word);
				end
				if (digest.word_index !== want.windex) begin
					mismatches++;
					$display("%0t: word_index expected %0d, got %0d", $time, want.windex,
						digest.word_index);
				end
				if (digest.last_word !== want.wlast) begin
					mismatches++;
					$display("%0t: last_word expected %b, got %b", $time, want.wlast,
						digest.last_word);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Main sequence. The length wrap of the bit count lies far beyond any run that can be
	// driven through the ports, so it is left to the predictor's arithmetic.
	initial begin : stimulus
		int msgs;
		int len;
		int start_beats;
		chain_h   = IV;
		bit_count = '0;
		block_buf = '{default: '0};
		arst_n           <= 1'b0;
		msg.valid        <= 1'b0;
		msg.msg_byte     <= 8'h00;
		msg.byte_present <= 1'b0;
		msg.message_end  <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (STIMULUS_TABLE[r])
			send_beat(STIMULUS_TABLE[r].data, STIMULUS_TABLE[r].present,
				STIMULUS_TABLE[r].closes, STIMULUS_TABLE[r].known, STIMULUS_TABLE[r].digest);

		// Ask for the long hold-off and keep sending short messages into it.
		hold_req <= 1'b1;
		start_beats = beats_sent;
		msgs = 0;
		while (beats_sent - start_beats < RANDOM_BEATS || msgs < MIN_RANDOM_MESSAGES) begin
			if (msgs < PILE_MESSAGES)
				len = $urandom_range(0, 4);
			else if ($urandom_range(0, 5) == 0)
				len = BOUNDARY_LENS[$urandom_range(0, 7)];
			else
				len = $urandom_range(0, 16);
			send_message(len);
			msgs++;
		end
		msg.valid <= 1'b0;

		while (pending_digest_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d data and end beats plus %0d idle beats; %0d random messages.",
			beats_sent, idle_beats, msgs);
		$display("Checked %0d digest words; the receiver held off for %0d cycles in one go.",
			words_checked, held_cycles);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
